FILE: sv/roi_depth_mean_defines.svh
// Assertion macros shared by the roi_depth_mean checker.
// No dependencies; include guarded.
`ifndef ROI_DEPTH_MEAN_DEFINES_SVH
`define ROI_DEPTH_MEAN_DEFINES_SVH

// Property sampled on the clock, switched off while reset is high
`define RDM_ASSERT_RUN(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Property sampled on the clock at every edge, reset included
`define RDM_ASSERT_ALL(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: sv/rdm_pkg.sv
// Shared constants, CSR register indices and controller/datapath structs
// for roi_depth_mean. No dependencies.
package rdm_pkg;

   // Sizing
   localparam int MAX_WIDTH   = 4096;
   localparam int MAX_HEIGHT  = 4096;
   localparam int SAMPLE_BITS = 16;

   // Fixed field widths
   localparam int SAMPLE_W   = 16;
   localparam int WIDTH_W    = 13;
   localparam int LEFT_W     = 12;
   localparam int TOP_W      = 12;
   localparam int COLS_W     = 13;
   localparam int ROWS_W     = 13;
   localparam int CSR_DATA_W = 13;
   localparam int CSR_IDX_W  = 3;
   localparam int SUM_W      = 40;
   localparam int COUNT_W    = 25;
   localparam int MEAN_W     = 16;

   // Derived widths
   localparam int COL_W     = $clog2(MAX_WIDTH);
   localparam int ROW_W     = $clog2(MAX_HEIGHT);
   localparam int POS_EXT_W = 16;
   localparam int STEP_W    = $clog2(SUM_W);

   localparam logic [SAMPLE_W-1:0] SAMPLE_MASK = SAMPLE_W'((64'd1 << SAMPLE_BITS) - 64'd1);
   localparam logic [SUM_W-1:0]    SAMPLE_MAX  = SUM_W'((64'd1 << SAMPLE_BITS) - 64'd1);

   // CSR reset values
   localparam logic [WIDTH_W-1:0] WIDTH_RST = WIDTH_W'(640);
   localparam logic [COLS_W-1:0]  COLS_RST  = COLS_W'(640);
   localparam logic [ROWS_W-1:0]  ROWS_RST  = ROWS_W'(480);

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_IMAGE_WIDTH = 3'd0,
      CSR_ROI_LEFT    = 3'd1,
      CSR_ROI_TOP     = 3'd2,
      CSR_ROI_COLUMNS = 3'd3,
      CSR_ROI_ROWS    = 3'd4
   } csr_index_type;

   // Controller to datapath
   typedef struct packed {
      logic accept;    // input transaction taken this cycle
      logic start;     // load divider from the closing frame
      logic step;      // one restoring-division step
      logic load_out;  // move quotient into the result register
   } dp_cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic div_last;  // final division step in progress
   } dp_sts_type;

endpackage

FILE: sv/rdm_ctrl.sv
// Controller for roi_depth_mean: accumulate / divide / deliver sequencing
// and the result valid flag. Depends on rdm_pkg.
module rdm_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   input  logic                req_frame_last,
   output logic                req_ready,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output rdm_pkg::dp_cmd_type cmd,
   input  rdm_pkg::dp_sts_type sts
);
   import rdm_pkg::*;

   typedef enum logic [2:0] {
      ST_ACC  = 3'b001,
      ST_DIV  = 3'b010,
      ST_DONE = 3'b100
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      take;

   assign req_ready = (state_ff == ST_ACC);
   assign take      = req_valid && req_ready;
   assign rsp_valid = rsp_valid_ff;

   // Next state and commands
   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      cmd          = '0;
      cmd.accept   = take;
      case (state_ff)
         ST_ACC: begin
            if (take && req_frame_last) begin
               cmd.start = 1'b1;
               state_in  = ST_DIV;
            end
         end
         ST_DIV: begin
            cmd.step = 1'b1;
            if (sts.div_last) state_in = ST_DONE;
         end
         ST_DONE: begin
            // output register free or being emptied this cycle
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.load_out = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_ACC;
            end
         end
         default: state_in = ST_ACC;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_ACC;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

FILE: sv/rdm_datapath.sv
// Datapath for roi_depth_mean: CSRs, raster position, rectangle test,
// saturating accumulators, bit-serial divider and result register. Depends on rdm_pkg.
module rdm_datapath (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_wr_en,
   input  logic [rdm_pkg::CSR_IDX_W-1:0]        csr_index,
   input  logic [rdm_pkg::CSR_DATA_W-1:0]       csr_wdata,
   input  logic [rdm_pkg::SAMPLE_W-1:0]         req_depth_sample,
   input  logic                                 req_frame_first,
   input  logic                                 req_frame_last,
   input  rdm_pkg::dp_cmd_type                  cmd,
   output rdm_pkg::dp_sts_type                  sts,
   output logic [rdm_pkg::MEAN_W-1:0]           rsp_mean_depth,
   output logic [rdm_pkg::COUNT_W-1:0]          rsp_sample_count
);
   import rdm_pkg::*;

   // Configuration registers
   logic [WIDTH_W-1:0] width_ff;
   logic [LEFT_W-1:0]  left_ff;
   logic [TOP_W-1:0]   top_ff;
   logic [COLS_W-1:0]  cols_ff;
   logic [ROWS_W-1:0]  rows_ff;

   // Frame state
   logic [COL_W-1:0]   col_ff, col_in, col_cur;
   logic [ROW_W-1:0]   row_ff, row_in, row_cur;
   logic [SUM_W-1:0]   sum_ff, sum_cur, sum_new;
   logic [COUNT_W-1:0] cnt_ff, cnt_cur, cnt_new;

   // Divider
   logic [SUM_W-1:0]   quo_ff;
   logic [COUNT_W-1:0] rem_ff, dvs_ff, res_cnt_ff;
   logic [STEP_W-1:0]  step_ff;
   logic [COUNT_W:0]   rem_sh, diff;
   logic               q_bit;

   // Result register
   logic [MEAN_W-1:0]  mean_ff;
   logic [COUNT_W-1:0] out_cnt_ff;

   logic [POS_EXT_W-1:0] eff_w, col_end, row_end, col_inc, row_inc, col_x, row_x;
   logic [SUM_W:0]       sum_add;
   logic [SAMPLE_W-1:0]  sample;
   logic                 in_roi;

   // CSR writes; unknown indices are dropped
   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff <= WIDTH_RST;
         left_ff  <= '0;
         top_ff   <= '0;
         cols_ff  <= COLS_RST;
         rows_ff  <= ROWS_RST;
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_IMAGE_WIDTH: width_ff <= csr_wdata[WIDTH_W-1:0];
            CSR_ROI_LEFT:    left_ff  <= csr_wdata[LEFT_W-1:0];
            CSR_ROI_TOP:     top_ff   <= csr_wdata[TOP_W-1:0];
            CSR_ROI_COLUMNS: cols_ff  <= csr_wdata[COLS_W-1:0];
            CSR_ROI_ROWS:    rows_ff  <= csr_wdata[ROWS_W-1:0];
            default: ;
         endcase
      end
   end

   // Rectangle test and accumulation for the incoming sample
   always_comb begin
      sample  = req_depth_sample & SAMPLE_MASK;
      col_cur = req_frame_first ? '0 : col_ff;
      row_cur = req_frame_first ? '0 : row_ff;
      sum_cur = req_frame_first ? '0 : sum_ff;
      cnt_cur = req_frame_first ? '0 : cnt_ff;

      // width clamp: zero acts as one, oversize acts as the maximum
      if (width_ff == '0)
         eff_w = POS_EXT_W'(1);
      else if (POS_EXT_W'(width_ff) > POS_EXT_W'(MAX_WIDTH))
         eff_w = POS_EXT_W'(MAX_WIDTH);
      else
         eff_w = POS_EXT_W'(width_ff);

      col_end = POS_EXT_W'(left_ff) + POS_EXT_W'(cols_ff);
      if (col_end > eff_w) col_end = eff_w;
      row_end = POS_EXT_W'(top_ff) + POS_EXT_W'(rows_ff);

      col_x  = POS_EXT_W'(col_cur);
      row_x  = POS_EXT_W'(row_cur);
      in_roi = (col_x >= POS_EXT_W'(left_ff)) && (col_x < col_end) &&
               (row_x >= POS_EXT_W'(top_ff)) && (row_x < row_end);

      sum_add = {1'b0, sum_cur} + (SUM_W + 1)'(sample);
      sum_new = sum_cur;
      cnt_new = cnt_cur;
      if (in_roi) begin
         sum_new = sum_add[SUM_W] ? '1 : sum_add[SUM_W-1:0];
         if (cnt_cur != '1) cnt_new = cnt_cur + COUNT_W'(1);
      end

      // raster advance
      col_inc = col_x + POS_EXT_W'(1);
      row_inc = row_x + POS_EXT_W'(1);
      if (col_inc >= eff_w) begin
         col_in = '0;
         row_in = (row_inc >= POS_EXT_W'(MAX_HEIGHT)) ? '0 : row_inc[ROW_W-1:0];
      end else begin
         col_in = col_inc[COL_W-1:0];
         row_in = row_cur;
      end
   end

   // Frame state; cleared after the closing sample
   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
         sum_ff <= '0;
         cnt_ff <= '0;
      end else if (cmd.accept) begin
         if (req_frame_last) begin
            col_ff <= '0;
            row_ff <= '0;
            sum_ff <= '0;
            cnt_ff <= '0;
         end else begin
            col_ff <= col_in;
            row_ff <= row_in;
            sum_ff <= sum_new;
            cnt_ff <= cnt_new;
         end
      end
   end

   // Restoring division step: one quotient bit per cycle
   always_comb begin
      rem_sh = {rem_ff, quo_ff[SUM_W-1]};
      diff   = rem_sh - {1'b0, dvs_ff};
      q_bit  = !diff[COUNT_W];
   end

   assign sts.div_last = (step_ff == STEP_W'(SUM_W - 1));

   always_ff @(posedge clock) begin
      if (cmd.start) begin
         quo_ff     <= sum_new;
         rem_ff     <= '0;
         dvs_ff     <= (cnt_new == '0) ? COUNT_W'(1) : cnt_new;
         res_cnt_ff <= cnt_new;
         step_ff    <= '0;
      end else if (cmd.step) begin
         rem_ff  <= q_bit ? diff[COUNT_W-1:0] : rem_sh[COUNT_W-1:0];
         quo_ff  <= {quo_ff[SUM_W-2:0], q_bit};
         step_ff <= step_ff + STEP_W'(1);
      end
   end

   // Result register, mean saturated at the largest sample
   always_ff @(posedge clock) begin
      if (cmd.load_out) begin
         mean_ff    <= (quo_ff > SAMPLE_MAX) ? SAMPLE_MAX[MEAN_W-1:0] : quo_ff[MEAN_W-1:0];
         out_cnt_ff <= res_cnt_ff;
      end
   end

   assign rsp_mean_depth   = mean_ff;
   assign rsp_sample_count = out_cnt_ff;

endmodule

FILE: sv/roi_depth_mean.sv
// roi_depth_mean: mean depth inside a rectangle of a raster-order depth frame.
// Throughput: one sample per cycle inside a frame (req_ready high while accumulating).
// After the frame_last transaction the input stalls while a 40-step bit-serial
// divider runs, then until the result register is loaded (later if it is still held).
// rsp_valid is registered and rises once the result register is loaded.
// Reset (synchronous): CSRs to defaults, position/sum/count cleared, no result pending.
module roi_depth_mean (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_wr_en,
   input  logic [rdm_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [rdm_pkg::CSR_DATA_W-1:0]  csr_wdata,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic [rdm_pkg::SAMPLE_W-1:0]    req_depth_sample,
   input  logic                            req_frame_first,
   input  logic                            req_frame_last,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic [rdm_pkg::MEAN_W-1:0]      rsp_mean_depth,
   output logic [rdm_pkg::COUNT_W-1:0]     rsp_sample_count
);
   import rdm_pkg::*;

   dp_cmd_type cmd;
   dp_sts_type sts;

   // Sequencing
   rdm_ctrl u_ctrl (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_frame_last (req_frame_last),
      .req_ready      (req_ready),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .cmd            (cmd),
      .sts            (sts)
   );

   // Arithmetic and storage
   rdm_datapath u_dp (
      .clock            (clock),
      .reset            (reset),
      .csr_wr_en        (csr_wr_en),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .req_depth_sample (req_depth_sample),
      .req_frame_first  (req_frame_first),
      .req_frame_last   (req_frame_last),
      .cmd              (cmd),
      .sts              (sts),
      .rsp_mean_depth   (rsp_mean_depth),
      .rsp_sample_count (rsp_sample_count)
   );

endmodule

FILE: sv/roi_depth_mean_chk.sv
// Port-level checker for roi_depth_mean, bound to the top level.
// Depends on rdm_pkg and roi_depth_mean_defines.svh.
`include "roi_depth_mean_defines.svh"

module roi_depth_mean_chk (
   input logic                            clock,
   input logic                            reset,
   input logic                            csr_wr_en,
   input logic [rdm_pkg::CSR_IDX_W-1:0]   csr_index,
   input logic [rdm_pkg::CSR_DATA_W-1:0]  csr_wdata,
   input logic                            req_valid,
   input logic                            req_ready,
   input logic [rdm_pkg::SAMPLE_W-1:0]    req_depth_sample,
   input logic                            req_frame_first,
   input logic                            req_frame_last,
   input logic                            rsp_valid,
   input logic                            rsp_ready,
   input logic [rdm_pkg::MEAN_W-1:0]      rsp_mean_depth,
   input logic [rdm_pkg::COUNT_W-1:0]     rsp_sample_count
);
   import rdm_pkg::*;

   // stalled result transaction holds
   `RDM_ASSERT_RUN(a_rsp_hold, clock, reset, (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_mean_depth) && $stable(rsp_sample_count)), "result changed while stalled")

   // empty rectangle gives a zero mean
   `RDM_ASSERT_RUN(a_empty_mean, clock, reset, (rsp_valid && (rsp_sample_count == '0)) |-> (rsp_mean_depth == '0), "non-zero mean with zero count")

   // closing sample stops intake while the divider runs
   `RDM_ASSERT_RUN(a_div_stall, clock, reset, (req_valid && req_ready && req_frame_last) |=> (!req_ready && !$rose(rsp_valid)), "intake or result right after frame end")

   // no result straight out of reset
   `RDM_ASSERT_ALL(a_reset_idle, clock, reset |=> (!rsp_valid && req_ready), "not idle after reset")

endmodule

bind roi_depth_mean roi_depth_mean_chk u_chk (.*);

FILE: dv/roi_depth_mean_checker.sv
`timescale 1ns / 100ps
// Checker for roi_depth_mean: watches the CSR port and both channels, predicts
// the per-frame mean and inside count, and compares every result transaction.
// Depends on rdm_pkg for widths and CSR register indices.
module roi_depth_mean_checker (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_wr_en,
   input  logic [rdm_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [rdm_pkg::CSR_DATA_W-1:0]  csr_wdata,
   input  logic                            req_valid,
   input  logic                            req_ready,
   input  logic [rdm_pkg::SAMPLE_W-1:0]    req_depth_sample,
   input  logic                            req_frame_first,
   input  logic                            req_frame_last,
   input  logic                            rsp_valid,
   input  logic                            rsp_ready,
   input  logic [rdm_pkg::MEAN_W-1:0]      rsp_mean_depth,
   input  logic [rdm_pkg::COUNT_W-1:0]     rsp_sample_count,
   output int                              mismatch_count,
   output int                              outstanding
);
   import rdm_pkg::*;

   typedef struct packed {
      logic [MEAN_W-1:0]  mean_depth;
      logic [COUNT_W-1:0] sample_count;
   } frame_mean_type;

   localparam logic [SUM_W-1:0] SUM_LIMIT = '1;

   // Shadow copy of the CSRs
   logic [WIDTH_W-1:0] cfg_width;
   logic [LEFT_W-1:0]  cfg_left;
   logic [TOP_W-1:0]   cfg_top;
   logic [COLS_W-1:0]  cfg_cols;
   logic [ROWS_W-1:0]  cfg_rows;

   // Frame position and accumulators
   logic [COL_W-1:0]   col_pos;
   logic [ROW_W-1:0]   row_pos;
   logic [SUM_W-1:0]   depth_total;
   logic [COUNT_W-1:0] hit_count;

   frame_mean_type frame_means_due[$];

   initial begin
      mismatch_count = 0;
      outstanding    = 0;
   end

   function automatic void restart_frame();
      col_pos     = '0;
      row_pos     = '0;
      depth_total = '0;
      hit_count   = '0;
   endfunction

   // Take one sample into the frame; returns 1 when it closes the frame
   function automatic bit absorb_sample(input logic [SAMPLE_W-1:0] sample_in,
                                        input logic first, input logic last,
                                        output frame_mean_type mean_out);
      logic [13:0]        eff_width;
      logic [13:0]        col_end;
      logic [13:0]        row_end;
      logic [SUM_W-1:0]   sample;
      logic [SUM_W-1:0]   divisor;
      logic [SUM_W-1:0]   quotient;
      logic               in_rect;
      sample = SUM_W'(sample_in & SAMPLE_MASK);
      mean_out = '0;
      // a zero width acts as one, anything past the maximum is clipped
      if (cfg_width == '0) begin
         eff_width = 14'd1;
      end else if (cfg_width > MAX_WIDTH) begin
         eff_width = 14'(MAX_WIDTH);
      end else begin
         eff_width = 14'(cfg_width);
      end
      if (first) restart_frame();

      col_end = 14'(cfg_left) + 14'(cfg_cols);
      if (col_end > eff_width) col_end = eff_width;
      row_end = 14'(cfg_top) + 14'(cfg_rows);
      in_rect = (col_pos >= cfg_left) && (14'(col_pos) < col_end) &&
                (row_pos >= cfg_top) && (14'(row_pos) < row_end);

      // saturating accumulation
      if (in_rect) begin
         if (depth_total > SUM_LIMIT - sample) depth_total = SUM_LIMIT;
         else depth_total = depth_total + sample;
         if (hit_count != '1) hit_count = hit_count + 1'b1;
      end

      if (last) begin
         divisor  = (hit_count == '0) ? SUM_W'(1) : SUM_W'(hit_count);
         quotient = depth_total / divisor;
         mean_out.mean_depth   = (quotient > SAMPLE_MAX) ? MEAN_W'(SAMPLE_MAX)
                                                         : quotient[MEAN_W-1:0];
         mean_out.sample_count = hit_count;
         restart_frame();
         return 1'b1;
      end

      // raster advance, rows wrap at the maximum height
      if (14'(col_pos) + 14'd1 >= eff_width) begin
         col_pos = '0;
         if (row_pos == ROW_W'(MAX_HEIGHT - 1)) row_pos = '0;
         else row_pos = row_pos + 1'b1;
      end else begin
         col_pos = col_pos + 1'b1;
      end
      return 1'b0;
   endfunction

   always @(posedge clock) begin : watch
      frame_mean_type seen;
      frame_mean_type want;
      frame_mean_type predicted;
      if (reset) begin
         cfg_width = WIDTH_RST;
         cfg_left  = '0;
         cfg_top   = '0;
         cfg_cols  = COLS_RST;
         cfg_rows  = ROWS_RST;
         restart_frame();
         frame_means_due.delete();
      end else begin
         // result side first: a result never belongs to a sample of this edge
         if (rsp_valid && rsp_ready) begin
            seen.mean_depth   = rsp_mean_depth;
            seen.sample_count = rsp_sample_count;
            if (frame_means_due.size() == 0) begin
               $error("unexpected result transaction: mean_depth %0d sample_count %0d",
                      seen.mean_depth, seen.sample_count);
               mismatch_count++;
            end else begin
               want = frame_means_due.pop_front();
               if (seen.mean_depth !== want.mean_depth) begin
                  $error("mean_depth: expected %0d, actual %0d",
                         want.mean_depth, seen.mean_depth);
                  mismatch_count++;
               end
               if (seen.sample_count !== want.sample_count) begin
                  $error("sample_count: expected %0d, actual %0d",
                         want.sample_count, seen.sample_count);
                  mismatch_count++;
               end
            end
         end

         if (csr_wr_en) begin
            case (csr_index)
               CSR_IMAGE_WIDTH: cfg_width = csr_wdata[WIDTH_W-1:0];
               CSR_ROI_LEFT:    cfg_left  = csr_wdata[LEFT_W-1:0];
               CSR_ROI_TOP:     cfg_top   = csr_wdata[TOP_W-1:0];
               CSR_ROI_COLUMNS: cfg_cols  = csr_wdata[COLS_W-1:0];
               CSR_ROI_ROWS:    cfg_rows  = csr_wdata[ROWS_W-1:0];
               default: ;
            endcase
         end

         if (req_valid && req_ready) begin
            if (absorb_sample(req_depth_sample, req_frame_first, req_frame_last,
                              predicted)) begin
               frame_means_due.push_back(predicted);
            end
         end
      end
      outstanding = frame_means_due.size();
   end

endmodule

FILE: dv/roi_depth_mean_test.sv
`timescale 1ns / 100ps
// Top of the roi_depth_mean testbench: clock, reset, CSR programming, sample
// stimulus and result back-pressure. Depends on rdm_pkg and roi_depth_mean_checker.
module roi_depth_mean_test;
   import rdm_pkg::*;

   localparam int DRAIN_CYCLES = 60;
   localparam int LONG_HOLD    = 400;

   logic                   clock            = 1'b0;
   logic                   reset            = 1'b1;
   logic                   csr_wr_en        = 1'b0;
   logic [CSR_IDX_W-1:0]   csr_index        = '0;
   logic [CSR_DATA_W-1:0]  csr_wdata        = '0;
   logic                   req_valid        = 1'b0;
   logic                   req_ready;
   logic [SAMPLE_W-1:0]    req_depth_sample = '0;
   logic                   req_frame_first  = 1'b0;
   logic                   req_frame_last   = 1'b0;
   logic                   rsp_valid;
   logic                   rsp_ready        = 1'b0;
   logic [MEAN_W-1:0]      rsp_mean_depth;
   logic [COUNT_W-1:0]     rsp_sample_count;

   int mismatch_count;
   int outstanding;
   int hold_req   = 0;
   int hold_done  = 0;
   bit quiet_tail = 1'b0;
   int shape_w    = 640;   // effective image width, used to shape frames

   roi_depth_mean u_dut (
      .clock            (clock),
      .reset            (reset),
      .csr_wr_en        (csr_wr_en),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_depth_sample (req_depth_sample),
      .req_frame_first  (req_frame_first),
      .req_frame_last   (req_frame_last),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_mean_depth   (rsp_mean_depth),
      .rsp_sample_count (rsp_sample_count)
   );

   roi_depth_mean_checker u_checker (
      .clock            (clock),
      .reset            (reset),
      .csr_wr_en        (csr_wr_en),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_depth_sample (req_depth_sample),
      .req_frame_first  (req_frame_first),
      .req_frame_last   (req_frame_last),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_mean_depth   (rsp_mean_depth),
      .rsp_sample_count (rsp_sample_count),
      .mismatch_count   (mismatch_count),
      .outstanding      (outstanding)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   initial begin
      #5_000_000;
      $display("TB_ERROR");
      $finish;
   end

   // Result back-pressure: random stalls, one long hold on request
   initial begin
      forever begin
         if (hold_req != hold_done) begin
            rsp_ready <= 1'b0;
            repeat (LONG_HOLD) @(posedge clock);
            hold_done++;
         end else if (!quiet_tail && $urandom_range(0, 5) == 0) begin
            rsp_ready <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge clock);
         end else begin
            rsp_ready <= 1'b1;
            repeat ($urandom_range(1, 20)) @(posedge clock);
         end
      end
   end

   function automatic logic [SAMPLE_W-1:0] pick_sample();
      case ($urandom_range(0, 7))
         0:       return '0;
         1:       return '1;
         default: return SAMPLE_W'($urandom_range(0, 65535));
      endcase
   endfunction

   // One sample transaction, optionally after a short idle burst
   task automatic send_item(input logic [SAMPLE_W-1:0] sample, input logic first,
                            input logic last, input bit gappy);
      if (gappy && !quiet_tail && $urandom_range(0, 5) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 5)) @(posedge clock);
      end
      req_valid        <= 1'b1;
      req_depth_sample <= sample;
      req_frame_first  <= first;
      req_frame_last   <= last;
      do @(posedge clock); while (!req_ready);
   endtask

   // Wait for every result, then for the divider to have gone quiet
   task automatic await_idle();
      req_valid <= 1'b0;
      // count is looked at mid-cycle, then back onto the rising edge
      do @(negedge clock); while (outstanding != 0);
      @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic put_csr(input csr_index_type idx, input int value);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= CSR_DATA_W'(value);
      @(posedge clock);
   endtask

   task automatic set_region(input int w, input int l, input int t, input int c,
                             input int r);
      put_csr(CSR_IMAGE_WIDTH, w);
      put_csr(CSR_ROI_LEFT, l);
      put_csr(CSR_ROI_TOP, t);
      put_csr(CSR_ROI_COLUMNS, c);
      put_csr(CSR_ROI_ROWS, r);
      csr_wr_en <= 1'b0;
      shape_w = (w == 0) ? 1 : (w > MAX_WIDTH) ? MAX_WIDTH : w;
   endtask

   // Mostly small images so frames close often; now and then an extreme
   task automatic random_region();
      int w;
      int eff;
      int l;
      int t;
      int c;
      int r;
      w = ($urandom_range(0, 5) == 0) ? $urandom_range(13, 8191) : $urandom_range(1, 12);
      eff = (w > MAX_WIDTH) ? MAX_WIDTH : w;
      l = ($urandom_range(0, 9) == 0) ? 4095 : $urandom_range(0, (eff + 1 > 4095) ? 4095
                                                                               : eff + 1);
      t = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 4095) : $urandom_range(0, 6);
      case ($urandom_range(0, 9))
         0:       c = 8191;
         1:       c = 0;
         default: c = $urandom_range(0, eff + 2);
      endcase
      r = ($urandom_range(0, 9) == 0) ? 8191 : $urandom_range(0, 7);
      set_region(w, l, t, c, r);
   endtask

   // Frames sized to the image, with the odd missing or stray flag
   task automatic run_frames(input int item_budget);
      int sent;
      int span;
      int k;
      bit gappy;
      bit with_first;
      bit with_last;
      sent = 0;
      while (sent < item_budget) begin
         span = (shape_w <= 16) ? shape_w * $urandom_range(1, 6) : $urandom_range(1, 48);
         if ($urandom_range(0, 9) == 0) span = $urandom_range(1, span * 2);
         gappy      = $urandom_range(0, 2) != 0;
         with_first = $urandom_range(0, 11) != 0;
         with_last  = $urandom_range(0, 14) != 0;
         for (k = 0; k < span; k++) begin
            send_item(pick_sample(),
                      (k == 0 && with_first) || $urandom_range(0, 39) == 0,
                      k == span - 1 && with_last, gappy);
         end
         sent += span;
      end
   endtask

   initial begin
      int k;
      int phase;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // directed, reset geometry: whole frame counts
      send_item(16'hFFFF, 1'b1, 1'b1, 1'b0);   // first and last together, top value
      send_item(16'h0000, 1'b1, 1'b1, 1'b0);
      send_item(16'hFFFF, 1'b1, 1'b0, 1'b0);
      send_item(16'h0000, 1'b0, 1'b0, 1'b0);
      send_item(16'h5555, 1'b0, 1'b1, 1'b0);
      send_item(16'hAAAA, 1'b0, 1'b0, 1'b0);   // new frame with no first flag
      send_item(16'h5555, 1'b0, 1'b1, 1'b0);
      send_item(16'h1234, 1'b1, 1'b0, 1'b0);
      send_item(16'h4321, 1'b0, 1'b0, 1'b0);
      send_item(16'h0FF0, 1'b1, 1'b0, 1'b0);   // first flag mid-frame restarts
      send_item(16'h0F0F, 1'b0, 1'b1, 1'b0);

      // rectangle running past the right edge of a 4-wide image
      await_idle();
      set_region(4, 1, 1, 8191, 2);
      for (k = 0; k < 12; k++) send_item(pick_sample(), k == 0, k == 11, 1'b0);

      // rectangle starting beyond the edge: empty, mean of zero
      await_idle();
      set_region(4, 4095, 0, 4, 4);
      send_item(16'hFFFF, 1'b1, 1'b0, 1'b0);
      send_item(16'hFFFF, 1'b0, 1'b1, 1'b0);

      // zero width acts as one: one sample per row
      await_idle();
      set_region(0, 0, 0, 1, 2);
      for (k = 0; k < 8; k++) begin
         send_item(pick_sample(), k == 0, k == 7, 1'b1);
      end

      // random phases, each under its own geometry
      for (phase = 0; phase < 10; phase++) begin
         await_idle();
         case (phase)
            0:       set_region(8191, 0, 0, 8191, 8191);
            1:       set_region(4096, 10, 0, 20, 1);
            2:       set_region(1, 0, 0, 1, 8191);
            default: random_region();
         endcase
         if (phase == 5) begin
            // receiver holds off while short frames keep coming
            hold_req++;
            for (k = 0; k < 60; k++) begin
               send_item(pick_sample(), 1'b1, 1'($urandom_range(0, 1)), 1'b0);
            end
         end
         if (phase == 9) quiet_tail = 1'b1;
         run_frames(115);
      end

      await_idle();
      if (mismatch_count == 0) $display("TB_OK");
      else $display("TB_ERROR");
      $finish;
   end

endmodule
